### rtl/ekht_pkg.sv
`default_nettype none
package ekht_pkg;

    localparam int TABLE_SLOTS = 4096;
    localparam int INDEX_BITS  = 24;
    localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
    localparam int COUNT_BITS  = SLOT_BITS + 1;
    localparam int FULL_LIMIT  = (TABLE_SLOTS * 3) / 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int NUM_LANES   = 3;

    localparam logic [SLOT_BITS-1:0]  SLOT_LAST  = SLOT_BITS'(TABLE_SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(FULL_LIMIT);

    localparam logic [31:0] QNAN_BITS  = 32'h7fc0_0000;
    localparam logic [31:0] HASH_MUL_Y = 32'd11;
    localparam logic [31:0] HASH_MUL_Z = 32'd17;
    localparam logic [31:0] HASH_MASK  = 32'h7fff_ffff;
    localparam int          HASH_SHR_HI = 22;
    localparam int          HASH_SHR_LO = 12;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FOUND = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [INDEX_BITS-1:0] vertex_a;
        logic [INDEX_BITS-1:0] vertex_b;
        logic [31:0]           a_x;
        logic [31:0]           a_y;
        logic [31:0]           a_z;
        logic [31:0]           b_x;
        logic [31:0]           b_y;
        logic [31:0]           b_z;
    } req_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0]  slot;
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] entries;
    } res_t;

    typedef struct packed {
        logic [1:0]            op;
        logic [INDEX_BITS-1:0] va;
        logic [INDEX_BITS-1:0] vb;
        logic [SLOT_BITS-1:0]  home;
    } q_item_t;

    typedef struct packed {
        logic                  valid;
        logic [INDEX_BITS-1:0] first;
        logic [INDEX_BITS-1:0] second;
    } slot_word_t;

    // Adder stage after operand classification and swap.
    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic        sign;
        logic        eff_sub;
        logic [7:0]  e;
        logic [7:0]  d;
        logic [26:0] mb;
        logic [26:0] ms;
    } fp_a_t;

    // Adder stage holding the raw sum and its exponent.
    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic        sign;
        logic [8:0]  e;
        logic [26:0] s;
    } fp_n_t;

    function automatic fp_a_t fp_prep(input logic [31:0] a, input logic [31:0] b);
        fp_a_t       r;
        logic [31:0] big;
        logic [31:0] sml;
        logic        a_nan;
        logic        b_nan;
        r = '0;
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        if (a_nan || b_nan)
        begin
            r.spec = 1'b1;
            r.spec_val = QNAN_BITS;
        end
        else if (a[30:23] == 8'hff)
        begin
            r.spec = 1'b1;
            r.spec_val = ((b[30:23] == 8'hff) && (a[31] != b[31])) ? QNAN_BITS : a;
        end
        else if (b[30:23] == 8'hff)
        begin
            r.spec = 1'b1;
            r.spec_val = b;
        end
        else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
        begin
            r.spec = 1'b1;
            r.spec_val = {a[31] & b[31], 31'd0};
        end
        else if (a[30:0] == 31'd0)
        begin
            r.spec = 1'b1;
            r.spec_val = b;
        end
        else if (b[30:0] == 31'd0)
        begin
            r.spec = 1'b1;
            r.spec_val = a;
        end
        r.sign = big[31];
        r.eff_sub = big[31] ^ sml[31];
        if (big[30:23] == 8'd0)
        begin
            r.e = 8'd1;
            r.mb = {1'b0, big[22:0], 3'b000};
        end
        else
        begin
            r.e = big[30:23];
            r.mb = {1'b1, big[22:0], 3'b000};
        end
        if (sml[30:23] == 8'd0)
        begin
            r.d = r.e - 8'd1;
            r.ms = {1'b0, sml[22:0], 3'b000};
        end
        else
        begin
            r.d = r.e - sml[30:23];
            r.ms = {1'b1, sml[22:0], 3'b000};
        end
        return r;
    endfunction

    function automatic fp_n_t fp_sum(input fp_a_t p);
        fp_n_t       r;
        logic [26:0] msh;
        logic [26:0] mask;
        logic [27:0] sum;
        logic [26:0] diff;
        logic [8:0]  e1;
        r.spec = p.spec;
        r.spec_val = p.spec_val;
        r.sign = p.sign;
        r.e = {1'b0, p.e};
        r.s = '0;
        mask = ~(27'h7ff_ffff << p.d[4:0]);
        if (p.d >= 8'd27)
        begin
            msh = {26'd0, |p.ms};
        end
        else
        begin
            msh = (p.ms >> p.d[4:0]) | {26'd0, |(p.ms & mask)};
        end
        if (!p.eff_sub)
        begin
            sum = {1'b0, p.mb} + {1'b0, msh};
            if (sum[27])
            begin
                e1 = {1'b0, p.e} + 9'd1;
                r.s = {sum[27:2], sum[1] | sum[0]};
                r.e = e1;
                if ((e1 >= 9'd255) && !p.spec)
                begin
                    r.spec = 1'b1;
                    r.spec_val = {p.sign, 8'hff, 23'd0};
                end
            end
            else
            begin
                r.s = sum[26:0];
            end
        end
        else
        begin
            diff = p.mb - msh;
            r.s = diff;
            if ((diff == 27'd0) && !p.spec)
            begin
                r.spec = 1'b1;
                r.spec_val = 32'd0;
            end
        end
        return r;
    endfunction

    // Left shift by the leading-zero count, held back so the exponent stays at least 1.
    function automatic fp_n_t fp_norm(input fp_n_t p);
        fp_n_t      r;
        logic [4:0] lz;
        logic [8:0] room;
        logic [4:0] sh;
        r = p;
        lz = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (p.s[i])
            begin
                lz = 5'(26 - i);
            end
        end
        room = p.e - 9'd1;
        sh = ({4'd0, lz} > room) ? room[4:0] : lz;
        r.s = p.s << sh;
        r.e = p.e - {4'd0, sh};
        return r;
    endfunction

    function automatic logic [31:0] fp_round(input fp_n_t p);
        logic [2:0]  low;
        logic [24:0] m25;
        logic [23:0] m;
        logic [8:0]  e;
        logic        inc;
        low = p.s[2:0];
        inc = (low > 3'd4) || ((low == 3'd4) && p.s[3]);
        m25 = {1'b0, p.s[26:3]} + {24'd0, inc};
        e = p.e;
        if (m25[24])
        begin
            m = m25[24:1];
            e = e + 9'd1;
        end
        else
        begin
            m = m25[23:0];
        end
        if (p.spec)
        begin
            return p.spec_val;
        end
        if (e >= 9'd255)
        begin
            return {p.sign, 8'hff, 23'd0};
        end
        if (!m[23])
        begin
            e = 9'd0;
        end
        return {p.sign, e[7:0], m[22:0]};
    endfunction

endpackage
`default_nettype wire

### rtl/edge_key_hash_table_core.sv
`default_nettype none
// Edge-key hash table with linear probing over 4096 slots. A request is taken
// when start is high and busy is low; exactly one result follows, shown on
// result for a single cycle with result_valid high, and it cannot be held off,
// so the receiver must take it in that cycle. The front part sums the two
// endpoint coordinates with three single-precision adders (four pipeline
// stages) and hashes the sums into a queued item. The back part then walks
// the table in a single-port memory with registered reads, reading and then
// checking each probed slot in turn. A clear request and the reset sequence
// both sweep the whole table one slot per cycle, with busy held high
// throughout; after reset, busy stays high until that sweep is done, so only
// then can the first request be taken. Only one request is in flight at a time.
module edge_key_hash_table_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire ekht_pkg::req_t request,
    output logic                result_valid,
    output ekht_pkg::res_t      result
);
    import ekht_pkg::*;

    logic    accept;
    logic    front_busy;
    logic    back_busy;
    logic    q_push;
    q_item_t q_push_item;
    logic    q_pop;
    q_item_t q_pop_item;
    logic    q_full;
    logic    q_empty;

    // Requests enter only when nothing else is in flight anywhere in the block.
    assign busy   = front_busy || !q_empty || back_busy;
    assign accept = start && !busy;

    ekht_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .request   (request),
        .busy      (front_busy),
        .push      (q_push),
        .push_item (q_push_item),
        .q_full    (q_full)
    );

    ekht_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    ekht_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (q_pop_item),
        .pop          (q_pop),
        .busy         (back_busy),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

### rtl/ekht_front.sv
`default_nettype none
module ekht_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire ekht_pkg::req_t  request,
    output logic                 busy,
    output logic                 push,
    output ekht_pkg::q_item_t    push_item,
    input  wire logic            q_full
);
    import ekht_pkg::*;

    // Stage valids: captured, prepared, summed, normalized, rounded, item ready.
    logic [5:0]  stage_reg;
    logic [5:0]  stage_next;
    req_t        req_reg;
    fp_a_t       prep_reg [NUM_LANES];
    fp_n_t       sum_reg  [NUM_LANES];
    fp_n_t       norm_reg [NUM_LANES];
    logic [31:0] res_reg  [NUM_LANES];
    q_item_t     item_reg;
    logic [31:0] op_a [NUM_LANES];
    logic [31:0] op_b [NUM_LANES];
    logic [31:0] mix;
    logic [31:0] fold;
    logic [31:0] hval;

    assign op_a[0] = req_reg.a_x;
    assign op_a[1] = req_reg.a_y;
    assign op_a[2] = req_reg.a_z;
    assign op_b[0] = req_reg.b_x;
    assign op_b[1] = req_reg.b_y;
    assign op_b[2] = req_reg.b_z;

    assign mix  = res_reg[0] + res_reg[1] * HASH_MUL_Y - res_reg[2] * HASH_MUL_Z;
    assign fold = mix & HASH_MASK;
    assign hval = (fold >> HASH_SHR_HI) ^ (fold >> HASH_SHR_LO) ^ fold;

    assign push      = stage_reg[5] && !q_full;
    assign push_item = item_reg;
    assign busy      = |stage_reg;

    always_comb
    begin
        stage_next = {stage_reg[4] || (stage_reg[5] && q_full), stage_reg[3:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        for (int i = 0; i < NUM_LANES; i++)
        begin
            prep_reg[i] <= fp_prep(op_a[i], op_b[i]);
            sum_reg[i]  <= fp_sum(prep_reg[i]);
            norm_reg[i] <= fp_norm(sum_reg[i]);
            res_reg[i]  <= fp_round(norm_reg[i]);
        end
        if (stage_reg[4])
        begin
            item_reg.op   <= req_reg.opcode;
            item_reg.va   <= req_reg.vertex_a;
            item_reg.vb   <= req_reg.vertex_b;
            item_reg.home <= hval[SLOT_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

### rtl/ekht_queue.sv
`default_nettype none
module ekht_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ekht_pkg::q_item_t push_item,
    input  wire logic              pop,
    output ekht_pkg::q_item_t      pop_item,
    output logic                   full,
    output logic                   empty
);
    import ekht_pkg::*;

    q_item_t                  entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]     wr_reg;
    logic [QPTR_BITS-1:0]     rd_reg;
    logic [QPTR_BITS:0]       fill_reg;
    logic [QPTR_BITS:0]       fill_next;

    assign full     = (fill_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_item = entry_reg[rd_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### rtl/ekht_back.sv
`default_nettype none
module ekht_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire ekht_pkg::q_item_t q_item,
    output logic                   pop,
    output logic                   busy,
    output logic                   result_valid,
    output ekht_pkg::res_t         result
);
    import ekht_pkg::*;

    typedef enum logic [4:0] {
        B_INIT  = 5'b00001,
        B_IDLE  = 5'b00010,
        B_READ  = 5'b00100,
        B_CHECK = 5'b01000,
        B_CLEAR = 5'b10000
    } back_state_t;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [SLOT_BITS-1:0]  probe_reg;
    logic [SLOT_BITS-1:0]  probe_next;
    logic [SLOT_BITS-1:0]  n_reg;
    logic [SLOT_BITS-1:0]  n_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    q_item_t               cur_reg;
    q_item_t               cur_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    res_t                  res_reg;
    res_t                  res_next;
    slot_word_t            mem [TABLE_SLOTS];
    slot_word_t            rdata_reg;
    slot_word_t            wdata;
    logic                  we;
    logic                  key_match;

    assign key_match = ((rdata_reg.first == cur_reg.va) && (rdata_reg.second == cur_reg.vb))
                    || ((rdata_reg.first == cur_reg.vb) && (rdata_reg.second == cur_reg.va));

    assign busy         = (state_reg != B_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        probe_next     = probe_reg;
        n_next         = n_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        pop            = 1'b0;
        we             = 1'b0;
        wdata          = '0;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        case (state_reg)
            B_INIT:
            begin
                we = 1'b1;
                probe_next = probe_reg + 1'b1;
                if (probe_reg == SLOT_LAST)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    cur_next = q_item;
                    probe_next = q_item.home;
                    n_next = '0;
                    case (q_item.op)
                        OP_INSERT:
                        begin
                            if (count_reg > COUNT_FULL)
                            begin
                                res_valid_next = 1'b1;
                                res_next.slot = '0;
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                state_next = B_READ;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            state_next = B_READ;
                        end
                        OP_CLEAR:
                        begin
                            probe_next = '0;
                            state_next = B_CLEAR;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            res_next.slot = '0;
                            res_next.status = ST_MISS;
                        end
                    endcase
                end
            end
            B_READ:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                if (cur_reg.op == OP_INSERT)
                begin
                    if (!rdata_reg.valid)
                    begin
                        we = 1'b1;
                        wdata.valid = 1'b1;
                        wdata.first = cur_reg.va;
                        wdata.second = cur_reg.vb;
                        count_next = count_reg + 1'b1;
                        res_valid_next = 1'b1;
                        res_next.slot = probe_reg;
                        res_next.status = ST_DONE;
                        state_next = B_IDLE;
                    end
                    else if (n_reg == SLOT_LAST)
                    begin
                        res_valid_next = 1'b1;
                        res_next.slot = '0;
                        res_next.status = ST_FULL;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        probe_next = probe_reg + 1'b1;
                        n_next = n_reg + 1'b1;
                        state_next = B_READ;
                    end
                end
                else
                begin
                    if (rdata_reg.valid && key_match)
                    begin
                        res_valid_next = 1'b1;
                        res_next.slot = probe_reg;
                        res_next.status = ST_FOUND;
                        state_next = B_IDLE;
                    end
                    else if (!rdata_reg.valid || (n_reg == SLOT_LAST))
                    begin
                        res_valid_next = 1'b1;
                        res_next.slot = '0;
                        res_next.status = ST_MISS;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        probe_next = probe_reg + 1'b1;
                        n_next = n_reg + 1'b1;
                        state_next = B_READ;
                    end
                end
            end
            B_CLEAR:
            begin
                we = 1'b1;
                probe_next = probe_reg + 1'b1;
                if (probe_reg == SLOT_LAST)
                begin
                    count_next = '0;
                    res_valid_next = 1'b1;
                    res_next.slot = '0;
                    res_next.status = ST_DONE;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (res_valid_next)
        begin
            res_next.entries = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            probe_reg     <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            probe_reg     <= probe_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[probe_reg] <= wdata;
        end
        rdata_reg <= mem[probe_reg];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (COUNT_FULL + 1'b1))
        else $error("entry count passed the fill limit");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |=> !res_valid_reg)
        else $error("two results in consecutive cycles");

    a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_INIT) |-> !res_valid_reg)
        else $error("result during the clearing pass after reset");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) && (state_reg != B_INIT) |->
            (count_reg == $past(count_reg) + 1'b1) || (count_reg == '0))
        else $error("entry count moved by more than one insert");

endmodule
`default_nettype wire

### verif/edge_key_hash_table_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
// Exercises the edge-key hash table through its start/busy request port and
// its one-cycle result strobe. Every accepted request is run through a local
// model of the table: single-precision sums of the endpoint coordinates, the
// hash of the sum words, and linear probing over the slots. The model's answer
// is queued, and each strobed result is compared field by field with the
// oldest queued answer.
module edge_key_hash_table_core_test;
    import ekht_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic result_valid;
    res_t result;

    edge_key_hash_table_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    // Local copy of the table contents.
    logic [INDEX_BITS-1:0] tbl_first [TABLE_SLOTS];
    logic [INDEX_BITS-1:0] tbl_second[TABLE_SLOTS];
    bit                    tbl_used  [TABLE_SLOTS];
    int unsigned           tbl_count;

    res_t        answers[$];
    int          fail_count;
    int unsigned send_gap_pct;
    longint      cycle_count;

    // Keys handed out by insert, so lookups usually hit something real.
    req_t        inserted[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Single-precision add with round to nearest even.
    function automatic logic [31:0] float_sum(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big;
        logic [31:0] sml;
        logic [31:0] mb;
        logic [31:0] ms;
        logic [31:0] s;
        logic [31:0] low;
        int          eb;
        int          es;
        int          d;
        int          e;
        logic        sign;
        if ((a[30:23] == 8'hff && a[22:0] != 0) || (b[30:23] == 8'hff && b[22:0] != 0))
            return QNAN_BITS;
        if (a[30:23] == 8'hff)
        begin
            if (b[30:23] == 8'hff && a[31] != b[31])
                return QNAN_BITS;
            return a;
        end
        if (b[30:23] == 8'hff)
            return b;
        if (a[30:0] == 0 && b[30:0] == 0)
            return {a[31] & b[31], 31'd0};
        if (a[30:0] == 0)
            return b;
        if (b[30:0] == 0)
            return a;
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        sign = big[31];
        eb = big[30:23];
        es = sml[30:23];
        mb = {9'd0, big[22:0]};
        ms = {9'd0, sml[22:0]};
        if (eb == 0) eb = 1; else mb[23] = 1'b1;
        if (es == 0) es = 1; else ms[23] = 1'b1;
        mb = mb << 3;
        ms = ms << 3;
        d = eb - es;
        if (d >= 27)
            ms = (ms != 0) ? 1 : 0;
        else if (d > 0)
            ms = (ms >> d) | (((ms & ((32'd1 << d) - 1)) != 0) ? 1 : 0);
        e = eb;
        if (big[31] == sml[31])
        begin
            s = mb + ms;
            if (s[27])
            begin
                s = (s >> 1) | (s & 1);
                e++;
                if (e >= 255)
                    return {sign, 8'hff, 23'd0};
            end
        end
        else
        begin
            s = mb - ms;
            if (s == 0)
                return 32'd0;
            while (!s[26] && e > 1)
            begin
                s = s << 1;
                e--;
            end
        end
        low = s & 7;
        s = s >> 3;
        if (low > 4 || (low == 4 && s[0]))
            s++;
        if (s[24])
        begin
            s = s >> 1;
            e++;
        end
        if (e >= 255)
            return {sign, 8'hff, 23'd0};
        if (!s[23])
            e = 0;
        return {sign, e[7:0], s[22:0]};
    endfunction

    function automatic int unsigned home_of(input req_t r);
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
        logic [31:0] f;
        logic [31:0] h;
        sx = float_sum(r.a_x, r.b_x);
        sy = float_sum(r.a_y, r.b_y);
        sz = float_sum(r.a_z, r.b_z);
        f = (sx + sy * HASH_MUL_Y - sz * HASH_MUL_Z) & HASH_MASK;
        h = (f >> HASH_SHR_HI) ^ (f >> HASH_SHR_LO) ^ f;
        return h & (TABLE_SLOTS - 1);
    endfunction

    function automatic void empty_table();
        foreach (tbl_used[i])
            tbl_used[i] = 1'b0;
        tbl_count = 0;
    endfunction

    // Applies one request to the local table and returns the expected result.
    function automatic res_t table_apply(input req_t r);
        res_t        o;
        int unsigned i;
        int unsigned n;
        o.slot = '0;
        o.status = ST_MISS;
        if (r.opcode == OP_INSERT)
        begin
            if (tbl_count * 4 > TABLE_SLOTS * 3)
                o.status = ST_FULL;
            else
            begin
                i = home_of(r);
                for (n = 0; n < TABLE_SLOTS && tbl_used[i]; n++)
                    i = (i + 1 >= TABLE_SLOTS) ? 0 : i + 1;
                if (!tbl_used[i])
                begin
                    tbl_first[i] = r.vertex_a;
                    tbl_second[i] = r.vertex_b;
                    tbl_used[i] = 1'b1;
                    tbl_count++;
                    o.slot = i[SLOT_BITS-1:0];
                    o.status = ST_DONE;
                end
                else
                    o.status = ST_FULL;
            end
        end
        else if (r.opcode == OP_LOOKUP)
        begin
            i = home_of(r);
            for (n = 0; n < TABLE_SLOTS && tbl_used[i]; n++)
            begin
                if ((tbl_first[i] == r.vertex_a && tbl_second[i] == r.vertex_b) ||
                    (tbl_first[i] == r.vertex_b && tbl_second[i] == r.vertex_a))
                begin
                    o.slot = i[SLOT_BITS-1:0];
                    o.status = ST_FOUND;
                    break;
                end
                i = (i + 1 >= TABLE_SLOTS) ? 0 : i + 1;
            end
        end
        else if (r.opcode == OP_CLEAR)
        begin
            empty_table();
            o.status = ST_DONE;
        end
        o.entries = tbl_count[COUNT_BITS-1:0];
        return o;
    endfunction

    // Sends one request: optional random idle cycles, then start held until
    // the block takes it. The answer is queued at the accepting edge.
    task automatic send_request(input req_t r);
        while ($urandom_range(99, 0) < send_gap_pct)
            @(negedge clk);
        // Leaves the falling edge that dropped start of the previous request.
        @(negedge clk);
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        answers.push_back(table_apply(r));
        if (r.opcode == OP_INSERT)
            inserted.push_back(r);
        else if (r.opcode == OP_CLEAR)
            inserted.delete();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Result checker: the strobe cannot be held off, so every strobe is taken.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && result_valid)
        begin
            if (answers.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result);
                fail_count++;
            end
            else
            begin
                want = answers.pop_front();
                if (result.slot !== want.slot)
                begin
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot, result.slot);
                    fail_count++;
                end
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             result.status);
                    fail_count++;
                end
                if (result.entries !== want.entries)
                begin
                    $display("%0t: entries expected %0d actual %0d", $time, want.entries,
                             result.entries);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog. Each clear sweeps the whole table, so the bound is generous.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 3000000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic wait_drained();
        while (answers.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] rand_float();
        case ($urandom_range(7, 0))
            0: return {$urandom_range(1, 0) == 1, 31'd0};
            1: return {$urandom_range(1, 0) == 1, 8'hff, 23'd0};
            2: return {$urandom_range(1, 0) == 1, 8'hff, 23'($urandom_range(8388607, 1))};
            3: return {$urandom_range(1, 0) == 1, 8'd0, 23'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    function automatic req_t rand_request(input logic [1:0] op);
        req_t r;
        r.opcode = op;
        r.vertex_a = ($urandom_range(3, 0) == 0) ? 24'($urandom()) : 24'($urandom_range(15, 0));
        r.vertex_b = ($urandom_range(3, 0) == 0) ? 24'($urandom()) : 24'($urandom_range(15, 0));
        r.a_x = rand_float();
        r.a_y = rand_float();
        r.a_z = rand_float();
        r.b_x = rand_float();
        r.b_y = rand_float();
        r.b_z = rand_float();
        return r;
    endfunction

    // A lookup of an earlier key, either order, same coordinates.
    function automatic req_t repeat_lookup();
        req_t                  r;
        logic [INDEX_BITS-1:0] v;
        r = inserted[$urandom_range(inserted.size() - 1, 0)];
        r.opcode = OP_LOOKUP;
        if ($urandom_range(1, 0) == 1)
        begin
            v = r.vertex_a;
            r.vertex_a = r.vertex_b;
            r.vertex_b = v;
        end
        return r;
    endfunction

    // Corner values of the fields, every opcode, and the adder special cases.
    task automatic test_directed();
        req_t r;
        r = '0;
        r.opcode = OP_LOOKUP;
        send_request(r);                              // empty table miss
        r.opcode = OP_INSERT;
        send_request(r);                              // key (0,0) is ordinary
        send_request(r);                              // duplicate goes further on
        r.opcode = OP_LOOKUP;
        send_request(r);
        r.opcode = OP_INSERT;
        r.vertex_a = '1;
        r.vertex_b = '1;
        r.a_x = 32'hffff_ffff;
        r.b_x = 32'h7f80_0000;
        r.a_y = 32'h7f80_0000;
        r.b_y = 32'hff80_0000;                        // inf minus inf
        r.a_z = 32'h8000_0000;
        r.b_z = 32'h8000_0000;                        // both negative zeros
        send_request(r);
        r.opcode = OP_LOOKUP;
        send_request(r);
        r.opcode = OP_INSERT;
        r.vertex_a = 24'd5;
        r.vertex_b = 24'd9;
        r.a_x = 32'h3f80_0000;
        r.b_x = 32'hbf80_0000;                        // exact cancellation
        r.a_y = 32'h7f7f_ffff;
        r.b_y = 32'h7f7f_ffff;                        // overflow to infinity
        r.a_z = 32'h0000_0001;
        r.b_z = 32'h807f_ffff;                        // subnormals
        send_request(r);
        r.opcode = OP_LOOKUP;
        r.vertex_a = 24'd9;
        r.vertex_b = 24'd5;                           // swapped order
        send_request(r);
        r.opcode = OP_UNUSED;
        send_request(r);
        r.opcode = OP_CLEAR;
        send_request(r);
        r.opcode = OP_LOOKUP;
        send_request(r);
    endtask

    // Inserts many keys with the same coordinates so they share one home
    // slot and build a long probe chain, looks some of them up, then clears.
    task automatic test_collisions();
        req_t r;
        for (int k = 0; k < 40; k++)
        begin
            r = '0;
            r.opcode = OP_INSERT;
            r.vertex_a = 24'(k);
            r.vertex_b = 24'($urandom());
            send_request(r);
        end
        wait_drained();
        send_request(repeat_lookup());
        send_request(repeat_lookup());
        r = '0;
        r.opcode = OP_LOOKUP;
        r.vertex_a = 24'd39;
        r.vertex_b = 24'd39;                          // walks the whole chain
        send_request(r);
        r.opcode = OP_CLEAR;
        send_request(r);
    endtask

    // Mostly inserts and lookups, many of known keys, with unused opcodes and clears now and then.
    task automatic test_random(input int unsigned count, input int unsigned gap);
        int unsigned pick;
        send_gap_pct = gap;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 45)
                send_request(rand_request(OP_INSERT));
            else if (pick < 80 && inserted.size() != 0)
                send_request(repeat_lookup());
            else if (pick < 94)
                send_request(rand_request(OP_LOOKUP));
            else if (pick < 97)
                send_request(rand_request(OP_UNUSED));
            else
                send_request(rand_request(OP_CLEAR));
        end
        // Hold off until every answer is in.
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        fail_count = 0;
        cycle_count = 0;
        send_gap_pct = 0;
        empty_table();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_collisions();
        test_random(110, 15);
        test_random(110, 74);
        test_random(120, 0);

        wait_drained();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
rtl/ekht_pkg.sv
rtl/ekht_front.sv
rtl/ekht_queue.sv
rtl/ekht_back.sv
rtl/edge_key_hash_table_core.sv
verif/edge_key_hash_table_core_test.sv
